>>> rtl/mbc1_pkg.sv
// ----------------------------------------------------------------------------
// MBC1 memory map package
// Shared types and constants for the memory map controller and datapath.
// ----------------------------------------------------------------------------
package mbc1_pkg;

    // Bus commands.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_MAPPER = 1'b0;
    localparam logic CFG_RAMPRS = 1'b1;

    localparam int DMA_BYTES = 160;
    localparam logic [15:0] DMA_ADDR = 16'hFF46;
    localparam logic [15:0] DIV_ADDR = 16'hFF04;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_DMA,
        ST_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       do_access;   // perform the latched CPU access
        logic       dma_start;   // clear DMA counter
        logic       dma_step;    // advance the DMA copy by one phase (read or write)
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic       is_dma;      // latched access is a DMA register write
        logic       dma_last;    // final DMA byte is being written
    } dp_stat_t;

    // Post-boot value of one IO register.
    function automatic logic [7:0] io_boot(input logic [6:0] idx);
        logic [7:0] v;
        begin
            v = 8'h00;
            case (idx)
                7'h00: v = 8'hCF; 7'h02: v = 8'h7E; 7'h04: v = 8'hAB;
                7'h07: v = 8'hF8; 7'h0F: v = 8'hE1; 7'h10: v = 8'h80;
                7'h11: v = 8'hBF; 7'h12: v = 8'hF3; 7'h13: v = 8'hFF;
                7'h14: v = 8'hBF; 7'h16: v = 8'h3F; 7'h18: v = 8'hFF;
                7'h19: v = 8'hBF; 7'h1A: v = 8'h7F; 7'h1B: v = 8'hFF;
                7'h1C: v = 8'h9F; 7'h1D: v = 8'hFF; 7'h1E: v = 8'hBF;
                7'h20: v = 8'hFF; 7'h23: v = 8'hBF; 7'h24: v = 8'h77;
                7'h25: v = 8'hF3; 7'h26: v = 8'hF1; 7'h40: v = 8'h91;
                7'h41: v = 8'h85; 7'h46: v = 8'hFF; 7'h47: v = 8'hFC;
                7'h4D: v = 8'hFF; 7'h4F: v = 8'hFF; 7'h51: v = 8'hFF;
                7'h52: v = 8'hFF; 7'h53: v = 8'hFF; 7'h54: v = 8'hFF;
                7'h55: v = 8'hFF; 7'h56: v = 8'hFF; 7'h68: v = 8'hFF;
                7'h69: v = 8'hFF; 7'h6A: v = 8'hFF; 7'h6B: v = 8'hFF;
                7'h70: v = 8'hFF;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/mbc1_ctrl.sv
// ----------------------------------------------------------------------------
// MBC1 memory map controller
// Sequences one bus item: accept, access, optional DMA copy, result hold.
// ----------------------------------------------------------------------------
module mbc1_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output mbc1_pkg::dp_cmd_t  cmd,
    input  mbc1_pkg::dp_stat_t stat
);

    mbc1_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbc1_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        cmd.do_access = 1'b0;
        cmd.dma_start = 1'b0;
        cmd.dma_step  = 1'b0;
        unique case (state_reg)
            mbc1_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = mbc1_pkg::ST_ACCESS;
            end
            mbc1_pkg::ST_ACCESS:
            begin
                cmd.do_access = 1'b1;
                cmd.dma_start = 1'b1;
                state_next = stat.is_dma ? mbc1_pkg::ST_DMA : mbc1_pkg::ST_DONE;
            end
            mbc1_pkg::ST_DMA:
            begin
                cmd.dma_step = 1'b1;
                if (stat.dma_last)
                    state_next = mbc1_pkg::ST_DONE;
            end
            mbc1_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                in_stall  = out_stall;
                if (!out_stall)
                    state_next = in_valid ? mbc1_pkg::ST_ACCESS : mbc1_pkg::ST_IDLE;
            end
            default: state_next = mbc1_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/mbc1_datapath.sv
// ----------------------------------------------------------------------------
// MBC1 memory map datapath
// Holds all stores and mapper registers; performs accesses and DMA steps.
// ----------------------------------------------------------------------------
module mbc1_datapath #(
    parameter int ROM_BANKS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_take,
    input  logic [1:0]         command,
    input  logic [15:0]        address,
    input  logic [16:0]        load_index,
    input  logic [7:0]         data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic               cfg_data,
    input  mbc1_pkg::dp_cmd_t  cmd,
    output mbc1_pkg::dp_stat_t stat,
    output logic [7:0]         read_data
);

    localparam int BANK_W = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;

    // Stores.
    logic [7:0] rom_mem   [131072];
    logic [7:0] vram_mem  [8192];
    logic [7:0] cram_mem  [8192];
    logic [7:0] wram_mem  [8192];
    logic [7:0] echo_mem  [7680];
    logic [7:0] oam_mem   [160];
    logic [7:0] forb_mem  [96];
    logic [7:0] hram_mem  [127];
    logic [7:0] io_mem    [128];
    logic [127:0] io_wr_reg;

    // Latched item.
    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [16:0] lidx_reg;
    logic [7:0]  data_reg;

    logic       mapper_reg, ramprs_reg, ram_en_reg;
    logic [4:0] bank_reg;
    logic [7:0] ie_reg;
    logic [7:0] rd_reg;

    // DMA state: phase 0 reads source, phase 1 writes OAM.
    logic [7:0] dma_cnt_reg;
    logic       dma_ph_reg;

    // Registered store outputs are valid the cycle after an access.
    logic reg_sel_valid;
    logic acc_d_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
            lidx_reg <= load_index;
            data_reg <= data;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_reg <= 1'b0;
            ramprs_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mbc1_pkg::CFG_MAPPER)
                mapper_reg <= cfg_data;
            else
                ramprs_reg <= cfg_data;
        end
    end

    // Read address: CPU access or DMA source.
    logic [15:0] ra;
    logic        is_wr;
    assign ra = cmd.dma_step ? {data_reg, dma_cnt_reg} : addr_reg;
    assign is_wr = (cmd_reg == mbc1_pkg::CMD_WRITE);

    // Bank number wrapped to the ROM size, from a table built at elaboration.
    logic [BANK_W-1:0] bank_wrap [32];
    for (genvar g = 0; g < 32; g++)
    begin : g_bank_wrap
        assign bank_wrap[g] = BANK_W'(g % ROM_BANKS);
    end

    logic [BANK_W-1:0] bank_mod;
    assign bank_mod = bank_wrap[bank_reg];
    logic [16:0] rom_a;
    always_comb
    begin
        if (ra < 16'h4000)
            rom_a = {3'b000, ra[13:0]};
        else
            rom_a = 17'(({{(17 - BANK_W){1'b0}}, bank_mod} << 14)) | {3'b000, ra[13:0]};
    end

    // Region decode of the read address.
    logic [7:0] rom_q, vram_q, cram_q, wram_q, echo_q, hram_q;
    logic [3:0] reg_sel_reg;
    logic [7:0] small_q_reg;
    logic       cram_ok_reg;

    always_ff @(posedge clk)
    begin
        rom_q  <= rom_mem[rom_a];
        vram_q <= vram_mem[ra[12:0]];
        cram_q <= cram_mem[ra[12:0]];
        wram_q <= wram_mem[ra[12:0]];
        echo_q <= echo_mem[13'(ra - 16'hE000)];
        hram_q <= hram_mem[7'(ra[6:0] == 7'h7F ? 7'h00 : ra[6:0])];
        cram_ok_reg <= ramprs_reg;
        if (ra < 16'h8000)      reg_sel_reg <= 4'd0;
        else if (ra < 16'hA000) reg_sel_reg <= 4'd1;
        else if (ra < 16'hC000) reg_sel_reg <= 4'd2;
        else if (ra < 16'hE000) reg_sel_reg <= 4'd3;
        else if (ra < 16'hFE00) reg_sel_reg <= 4'd4;
        else if (ra < 16'hFF80 || ra == 16'hFFFF) reg_sel_reg <= 4'd5;
        else                    reg_sel_reg <= 4'd6;
        // Small stores read from flops.
        if (ra < 16'hFEA0)      small_q_reg <= oam_mem[8'(ra - 16'hFE00)];
        else if (ra < 16'hFF00) small_q_reg <= forb_mem[7'(ra - 16'hFEA0)];
        else if (ra < 16'hFF80)
            small_q_reg <= io_wr_reg[ra[6:0]] ? io_mem[ra[6:0]]
                                               : mbc1_pkg::io_boot(ra[6:0]);
        else                    small_q_reg <= ie_reg;
    end

    // Read mux after the registered store outputs.
    logic [7:0] rd_val;
    always_comb
    begin
        case (reg_sel_reg)
            4'd0: rd_val = rom_q;
            4'd1: rd_val = vram_q;
            4'd2: rd_val = cram_ok_reg ? cram_q : 8'h00;
            4'd3: rd_val = wram_q;
            4'd4: rd_val = echo_q;
            4'd5: rd_val = small_q_reg;
            default: rd_val = hram_q;
        endcase
    end

    // Status toward the controller.
    assign stat.is_dma   = is_wr && (addr_reg == mbc1_pkg::DMA_ADDR);
    assign stat.dma_last = dma_ph_reg && (dma_cnt_reg == 8'(mbc1_pkg::DMA_BYTES - 1));

    // Write side of the stores: ROM loads, CPU writes and DMA writes to OAM.
    logic wr_now;
    assign wr_now = cmd.do_access && is_wr;
    always_ff @(posedge clk)
    begin
        if (cmd.do_access && cmd_reg == mbc1_pkg::CMD_LOAD)
            rom_mem[lidx_reg] <= data_reg;
        if (wr_now && addr_reg[15:13] == 3'b100)
            vram_mem[addr_reg[12:0]] <= data_reg;
        if (wr_now && addr_reg[15:13] == 3'b101 && ramprs_reg && (!mapper_reg || ram_en_reg))
            cram_mem[addr_reg[12:0]] <= data_reg;
        if (wr_now && addr_reg[15:13] == 3'b110)
            wram_mem[addr_reg[12:0]] <= data_reg;
        if (wr_now && addr_reg >= 16'hE000 && addr_reg < 16'hFE00)
            echo_mem[13'(addr_reg - 16'hE000)] <= data_reg;
        if (wr_now && addr_reg >= 16'hFF80 && addr_reg != 16'hFFFF)
            hram_mem[addr_reg[6:0]] <= data_reg;
        if (wr_now && addr_reg >= 16'hFEA0 && addr_reg < 16'hFF00)
            forb_mem[7'(addr_reg - 16'hFEA0)] <= data_reg;
        if (wr_now && addr_reg >= 16'hFE00 && addr_reg < 16'hFEA0)
            oam_mem[8'(addr_reg - 16'hFE00)] <= data_reg;
        else if (cmd.dma_step && dma_ph_reg)
            oam_mem[dma_cnt_reg] <= rd_val;
        if (wr_now && addr_reg[15:7] == 9'h1FE)
            io_mem[addr_reg[6:0]] <= (addr_reg == mbc1_pkg::DIV_ADDR) ? 8'h00 : data_reg;
    end

    // Control registers: mapper, IE, IO written marks, DMA, result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_en_reg  <= 1'b0;
            bank_reg    <= 5'd1;
            ie_reg      <= 8'h00;
            io_wr_reg   <= '0;
            dma_cnt_reg <= 8'h00;
            dma_ph_reg  <= 1'b0;
            rd_reg      <= 8'h00;
        end
        else
        begin
            if (wr_now && mapper_reg && addr_reg < 16'h2000)
                ram_en_reg <= (data_reg[3:0] == 4'hA);
            else if (wr_now && mapper_reg && addr_reg < 16'h4000 && addr_reg >= 16'h2000)
                bank_reg <= (data_reg[4:0] == 5'd0) ? 5'd1 : data_reg[4:0];
            if (wr_now && addr_reg == 16'hFFFF)
                ie_reg <= data_reg;
            if (wr_now && addr_reg[15:7] == 9'h1FE)
                io_wr_reg[addr_reg[6:0]] <= 1'b1;
            if (cmd.dma_start)
            begin
                dma_cnt_reg <= 8'h00;
                dma_ph_reg  <= 1'b0;
            end
            else if (cmd.dma_step)
            begin
                dma_ph_reg <= ~dma_ph_reg;
                if (dma_ph_reg)
                    dma_cnt_reg <= dma_cnt_reg + 8'd1;
            end
            if (cmd.do_access)
                rd_reg <= 8'h00;
            else if (!cmd.dma_step && cmd_reg == mbc1_pkg::CMD_READ && reg_sel_valid)
                rd_reg <= rd_val;
        end
    end

    // The read result is captured the cycle after the access.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_d_reg <= 1'b0;
        else
            acc_d_reg <= cmd.do_access;
    end
    assign reg_sel_valid = acc_d_reg;

    // In the first result cycle a read byte comes straight from the store output.
    assign read_data = (reg_sel_valid && cmd_reg == mbc1_pkg::CMD_READ) ? rd_val : rd_reg;

endmodule

>>> rtl/handheld_memory_map_mbc1.sv
// ----------------------------------------------------------------------------
// Handheld memory map with MBC1
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Usage: an item on the input channel (command, address, load_index, data)
// transfers when in_valid is high and in_stall low. One read_data result per
// item appears on the output channel with out_valid and transfers when
// out_stall is low. A plain item is latched, then makes one synchronous
// memory access; the result is then held in a register.
// A write of the DMA register adds a copy of 160 bytes: each byte needs
// one memory read and one sprite-table write.
// A new item transfers in the cycle its predecessor's result transfers.
// While the receiver stalls, the result holds and no new item is taken.
// Reset restores the IO registers to post-boot values, bank one, RAM
// disabled, interrupt enable zero, and both configuration registers zero.
// Configuration writes go through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module handheld_memory_map_mbc1 #(
    parameter int ROM_BANKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] address,
    input  logic [16:0] load_index,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    mbc1_pkg::dp_cmd_t  cmd;
    mbc1_pkg::dp_stat_t stat;
    logic in_take;
    assign in_take = in_valid && !in_stall;

    mbc1_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    mbc1_datapath #(.ROM_BANKS(ROM_BANKS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_take(in_take), .command(command),
        .address(address), .load_index(load_index), .data(data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .stat(stat), .read_data(read_data)
    );

    // A result is never offered while an access is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_access |-> !out_valid) else $error("result during access");

    // An accepted item is accessed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> cmd.do_access) else $error("accepted item not accessed");

    // DMA steps and accesses never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.dma_step && cmd.do_access)) else $error("dma overlaps access");

endmodule

>>> tb/sv/handheld_memory_map_mbc1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory map checker
// Watches both channels and the configuration port of the memory map. It
// keeps its own copy of every store and register, predicts the byte that
// each accepted bus item returns, and compares it with each result transfer.
// ----------------------------------------------------------------------------
module handheld_memory_map_mbc1_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] address,
    input  logic [16:0] load_index,
    input  logic [7:0]  data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output int          error_count,
    output int          outstanding
);

    localparam int BANK_COUNT = 8;

    // Shadow copy of the block state.
    logic [7:0] rom_img [131072];
    logic [7:0] vram [8192];
    logic [7:0] cram [8192];
    logic [7:0] wram [8192];
    logic [7:0] echo [7680];
    logic [7:0] oam [160];
    logic [7:0] unusable [96];
    logic [7:0] io [128];
    logic [7:0] hram [127];
    logic [7:0] ie_reg;
    logic [4:0] bank_sel;
    logic       cram_enabled;
    logic       mapper_mbc1;
    logic       cram_fitted;

    logic [7:0] read_bytes_due [$];

    assign outstanding = read_bytes_due.size();

    // Post-boot IO contents.
    function automatic logic [7:0] boot_io(input int idx);
        case (idx)
            'h00: return 8'hCF; 'h02: return 8'h7E; 'h04: return 8'hAB;
            'h07: return 8'hF8; 'h0F: return 8'hE1; 'h10: return 8'h80;
            'h11: return 8'hBF; 'h12: return 8'hF3; 'h13: return 8'hFF;
            'h14: return 8'hBF; 'h16: return 8'h3F; 'h18: return 8'hFF;
            'h19: return 8'hBF; 'h1A: return 8'h7F; 'h1B: return 8'hFF;
            'h1C: return 8'h9F; 'h1D: return 8'hFF; 'h1E: return 8'hBF;
            'h20: return 8'hFF; 'h23: return 8'hBF; 'h24: return 8'h77;
            'h25: return 8'hF3; 'h26: return 8'hF1; 'h40: return 8'h91;
            'h41: return 8'h85; 'h46: return 8'hFF; 'h47: return 8'hFC;
            'h4D: return 8'hFF; 'h4F: return 8'hFF; 'h51: return 8'hFF;
            'h52: return 8'hFF; 'h53: return 8'hFF; 'h54: return 8'hFF;
            'h55: return 8'hFF; 'h56: return 8'hFF; 'h68: return 8'hFF;
            'h69: return 8'hFF; 'h6A: return 8'hFF; 'h6B: return 8'hFF;
            'h70: return 8'hFF;
            default: return 8'h00;
        endcase
    endfunction

    // Byte seen by a bus read at one address.
    function automatic logic [7:0] bus_fetch(input logic [15:0] a);
        int unsigned pos;
        if (a < 16'h4000)
            return rom_img[a];
        if (a < 16'h8000)
        begin
            pos = (int'(bank_sel) % BANK_COUNT) * 16384 + (a - 16'h4000);
            return rom_img[pos & 32'h1FFFF];
        end
        if (a < 16'hA000) return vram[a - 16'h8000];
        if (a < 16'hC000) return cram_fitted ? cram[a - 16'hA000] : 8'h00;
        if (a < 16'hE000) return wram[a - 16'hC000];
        if (a < 16'hFE00) return echo[a - 16'hE000];
        if (a < 16'hFEA0) return oam[a - 16'hFE00];
        if (a < 16'hFF00) return unusable[a - 16'hFEA0];
        if (a < 16'hFF80) return io[a - 16'hFF00];
        if (a < 16'hFFFF) return hram[a - 16'hFF80];
        return ie_reg;
    endfunction

    // Effect of a bus write, including the bank controller and sprite DMA.
    task automatic bus_store(input logic [15:0] a, input logic [7:0] v);
        if (a < 16'h8000)
        begin
            if (mapper_mbc1)
            begin
                if (a < 16'h2000)
                    cram_enabled = (v[3:0] == 4'hA);
                else if (a < 16'h4000)
                    bank_sel = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
            end
        end
        else if (a < 16'hA000) vram[a - 16'h8000] = v;
        else if (a < 16'hC000)
        begin
            if (cram_fitted && (!mapper_mbc1 || cram_enabled))
                cram[a - 16'hA000] = v;
        end
        else if (a < 16'hE000) wram[a - 16'hC000] = v;
        else if (a < 16'hFE00) echo[a - 16'hE000] = v;
        else if (a < 16'hFEA0) oam[a - 16'hFE00] = v;
        else if (a < 16'hFF00) unusable[a - 16'hFEA0] = v;
        else if (a < 16'hFF80)
        begin
            if (a == mbc1_pkg::DIV_ADDR)
                io[a - 16'hFF00] = 8'h00;
            else if (a == mbc1_pkg::DMA_ADDR)
            begin
                io[a - 16'hFF00] = v;
                for (int i = 0; i < mbc1_pkg::DMA_BYTES; i++)
                    oam[i] = bus_fetch({v, 8'(i)});
            end
            else
                io[a - 16'hFF00] = v;
        end
        else if (a < 16'hFFFF) hram[a - 16'hFF80] = v;
        else ie_reg = v;
    endtask

    // Track transfers, predict and compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 128; i++)
                io[i] = boot_io(i);
            ie_reg = 8'h00;
            bank_sel = 5'd1;
            cram_enabled = 1'b0;
            mapper_mbc1 = 1'b0;
            cram_fitted = 1'b0;
            error_count <= 0;
            read_bytes_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == mbc1_pkg::CFG_MAPPER)
                    mapper_mbc1 = cfg_data;
                else
                    cram_fitted = cfg_data;
            end
            // Result transfer against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (read_bytes_due.size() == 0)
                begin
                    $display("%0t ERROR unexpected result: expected none, actual %02h",
                             $time, read_data);
                    error_count <= error_count + 1;
                end
                else if (read_data !== read_bytes_due[0])
                begin
                    $display("%0t ERROR read_data: expected %02h, actual %02h",
                             $time, read_bytes_due[0], read_data);
                    error_count <= error_count + 1;
                    void'(read_bytes_due.pop_front());
                end
                else
                    void'(read_bytes_due.pop_front());
            end
            // Bus item transfer.
            if (in_valid && !in_stall)
            begin
                case (command)
                    mbc1_pkg::CMD_READ:  read_bytes_due.push_back(bus_fetch(address));
                    mbc1_pkg::CMD_WRITE:
                    begin
                        bus_store(address, data);
                        read_bytes_due.push_back(8'h00);
                    end
                    mbc1_pkg::CMD_LOAD:
                    begin
                        rom_img[load_index] = data;
                        read_bytes_due.push_back(8'h00);
                    end
                    default:   read_bytes_due.push_back(8'h00);
                endcase
            end
        end
    end

endmodule

>>> tb/sv/handheld_memory_map_mbc1_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory map testbench
// Drives bus items with random gaps and random result stalls through several
// mapper and cartridge RAM settings, and only ever reads bytes with a known value.
// The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module handheld_memory_map_mbc1_tb;

    localparam int PHASE_ITEMS = 390;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [15:0] address;
    logic [16:0] load_index;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;
    int          error_count;
    int          outstanding;

    // Which entries hold a known value, and a mirror of the bank controller.
    bit          rom_known [131072];
    bit          bus_known [65536];
    logic [4:0]  bank_mirror;
    bit          ram_on_mirror;
    bit          mbc1_on;
    bit          cram_on;
    logic [15:0] known_addrs [$];
    int          idle_cycles;
    int          stall_left;
    bit          stall_now;
    bit          quiet_spell;
    int          sent_items;
    int          phase_end;
    bit          half_done;

    handheld_memory_map_mbc1 DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .address(address), .load_index(load_index), .data(data),
        .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    handheld_memory_map_mbc1_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .address(address), .load_index(load_index), .data(data),
        .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .outstanding(outstanding)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result stalls: random runs, with quiet spells of no stall.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            if ($urandom_range(0, 19) == 0)
                quiet_spell <= !quiet_spell;
            stall_now = !quiet_spell && ($urandom_range(0, 2) == 0);
            out_stall <= stall_now;
            stall_left <= stall_now ? (($urandom_range(0, 9) == 0) ?
                          $urandom_range(10, 40) : $urandom_range(0, 2)) :
                          $urandom_range(0, 4);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL handheld_memory_map_mbc1");
            $finish;
        end
    end

    // True when a read of this address returns a known byte.
    function automatic bit is_known(input logic [15:0] a);
        int unsigned pos;
        if (a < 16'h4000) return rom_known[a];
        if (a < 16'h8000)
        begin
            pos = (int'(bank_mirror) % 8) * 16384 + (a - 16'h4000);
            return rom_known[pos];
        end
        if (a >= 16'hA000 && a < 16'hC000) return !cram_on || bus_known[a];
        if (a >= 16'hFF00 && a < 16'hFF80) return 1'b1;
        if (a == 16'hFFFF) return 1'b1;
        return bus_known[a];
    endfunction

    function automatic bit dma_source_known(input logic [7:0] page);
        for (int i = 0; i < mbc1_pkg::DMA_BYTES; i++)
            if (!is_known({page, 8'(i)}))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void remember(input logic [15:0] a);
        known_addrs.push_back(a);
        if (known_addrs.size() > 512)
            void'(known_addrs.pop_front());
    endfunction

    // Keep the known-value map in step with each item sent.
    function automatic void note_item(input logic [1:0] cmd, input logic [15:0] a,
                                      input logic [16:0] idx, input logic [7:0] d);
        if (cmd == mbc1_pkg::CMD_LOAD)
        begin
            rom_known[idx] = 1'b1;
            if (idx < 17'h4000)
                remember(16'(idx));
            else
                remember(16'h4000 | 16'(idx[13:0]));
        end
        else if (cmd == mbc1_pkg::CMD_WRITE)
        begin
            if (a < 16'h8000)
            begin
                if (mbc1_on && a < 16'h2000)
                    ram_on_mirror = (d[3:0] == 4'hA);
                else if (mbc1_on && a < 16'h4000)
                    bank_mirror = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
            end
            else if (a >= 16'hA000 && a < 16'hC000)
            begin
                if (cram_on && (!mbc1_on || ram_on_mirror))
                begin
                    bus_known[a] = 1'b1;
                    remember(a);
                end
            end
            else if (a == mbc1_pkg::DMA_ADDR)
            begin
                for (int i = 0; i < mbc1_pkg::DMA_BYTES; i++)
                    bus_known[16'hFE00 + i] = 1'b1;
            end
            else
            begin
                bus_known[a] = 1'b1;
                remember(a);
            end
        end
    endfunction

    // One bus item, after a random gap; returns once it has transferred.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] a,
                             input logic [16:0] idx, input logic [7:0] d);
        int gap;
        gap = ($urandom_range(0, 99) < 70) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note_item(cmd, a, idx, d);
        command <= cmd;
        address <= a;
        load_index <= idx;
        data <= d;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_items++;
    endtask

    // Hold off the sender until all results are in, then optionally settle.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_config(input bit mapper, input bit ram_fitted);
        cfg_we <= 1'b1;
        cfg_index <= mbc1_pkg::CFG_MAPPER;
        cfg_data <= mapper;
        @(posedge clk);
        cfg_index <= mbc1_pkg::CFG_RAMPRS;
        cfg_data <= ram_fitted;
        @(posedge clk);
        cfg_we <= 1'b0;
        mbc1_on = mapper;
        cram_on = ram_fitted;
    endtask

    // Address spread over every region of the map.
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(16'h0000, 16'h7FFF));
            1: return 16'($urandom_range(16'h8000, 16'h9FFF));
            2: return 16'($urandom_range(16'hA000, 16'hBFFF));
            3: return 16'($urandom_range(16'hC000, 16'hDFFF));
            4: return 16'($urandom_range(16'hE000, 16'hFDFF));
            5: return 16'($urandom_range(16'hFE00, 16'hFE9F));
            6: return 16'($urandom_range(16'hFEA0, 16'hFEFF));
            7: return 16'($urandom_range(16'hFF00, 16'hFF7F));
            8: return 16'($urandom_range(16'hFF80, 16'hFFFE));
            default: return ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        endcase
    endfunction

    // Fill one page with writes, then start a sprite DMA from it.
    task automatic fill_and_copy();
        logic [7:0] page;
        page = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'h9F)) :
               8'($urandom_range(8'hC0, 8'hFD));
        for (int i = 0; i < mbc1_pkg::DMA_BYTES; i++)
            send_item(mbc1_pkg::CMD_WRITE, {page, 8'(i)}, 17'($urandom), 8'($urandom));
        send_item(mbc1_pkg::CMD_WRITE, mbc1_pkg::DMA_ADDR, 17'($urandom), page);
    endtask

    task automatic random_item();
        int          pick;
        logic [15:0] a;
        logic [7:0]  d;
        pick = $urandom_range(0, 199);
        a = pick_address();
        d = 8'($urandom);
        if (pick < 6)
            send_item(mbc1_pkg::CMD_NOP, 16'($urandom), 17'($urandom), d);
        else if (pick < 50)
            send_item(mbc1_pkg::CMD_LOAD, 16'($urandom), 17'($urandom_range(0, 131071)), d);
        else if (pick < 120)
        begin
            if (a < 16'h2000 && $urandom_range(0, 1) == 0)
                d = {d[7:4], 4'hA};
            if (a == mbc1_pkg::DMA_ADDR && !dma_source_known(d))
                a = 16'hFF47;
            send_item(mbc1_pkg::CMD_WRITE, a, 17'($urandom), d);
        end
        else if (pick < 198)
        begin
            if (!is_known(a) && known_addrs.size() > 0)
                a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
            if (!is_known(a))
                a = 16'hFF00 | 16'($urandom_range(0, 127));
            send_item(mbc1_pkg::CMD_READ, a, 17'($urandom), d);
        end
        else if (dma_source_known(d))
            send_item(mbc1_pkg::CMD_WRITE, mbc1_pkg::DMA_ADDR, 17'($urandom), d);
        else
            fill_and_copy();
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        command <= mbc1_pkg::CMD_NOP;
        address <= 16'h0000;
        load_index <= 17'h0;
        data <= 8'h00;
        cfg_we <= 1'b0;
        cfg_index <= mbc1_pkg::CFG_MAPPER;
        cfg_data <= 1'b0;
        out_stall <= 1'b0;
        stall_left = 0;
        quiet_spell = 1'b0;
        idle_cycles = 0;
        sent_items = 0;
        bank_mirror = 5'd1;
        ram_on_mirror = 1'b0;
        mbc1_on = 1'b0;
        cram_on = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(1'b1, 1'b1);

        // Directed: ROM extremes, bank select, RAM enable, DIV, IE and no-op.
        send_item(mbc1_pkg::CMD_LOAD, 16'h0, 17'h00000, 8'h3C);
        send_item(mbc1_pkg::CMD_LOAD, 16'h0, 17'h1FFFF, 8'hC3);
        send_item(mbc1_pkg::CMD_LOAD, 16'h0, 17'h04000, 8'h5A);
        send_item(mbc1_pkg::CMD_LOAD, 16'h0, 17'h03FFF, 8'hFF);
        send_item(mbc1_pkg::CMD_READ, 16'h0000, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_READ, 16'h3FFF, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_READ, 16'h4000, 17'h0, 8'h00);
        // Bank zero turns into bank one.
        send_item(mbc1_pkg::CMD_WRITE, 16'h2000, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_READ, 16'h4000, 17'h0, 8'h00);
        // Bank 31 wraps onto the last bank of the image.
        send_item(mbc1_pkg::CMD_WRITE, 16'h3FFF, 17'h0, 8'hFF);
        send_item(mbc1_pkg::CMD_READ, 16'h7FFF, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_WRITE, 16'h0000, 17'h0, 8'h0A);
        send_item(mbc1_pkg::CMD_WRITE, 16'hA000, 17'h0, 8'h11);
        send_item(mbc1_pkg::CMD_READ, 16'hA000, 17'h0, 8'h00);
        // A disabled RAM drops the write but still reads back.
        send_item(mbc1_pkg::CMD_WRITE, 16'h1FFF, 17'h0, 8'hFB);
        send_item(mbc1_pkg::CMD_WRITE, 16'hA000, 17'h0, 8'h22);
        send_item(mbc1_pkg::CMD_READ, 16'hA000, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_WRITE, mbc1_pkg::DIV_ADDR, 17'h0, 8'h55);
        send_item(mbc1_pkg::CMD_READ, mbc1_pkg::DIV_ADDR, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_READ, 16'hFF00, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_WRITE, 16'hFFFF, 17'h0, 8'hFF);
        send_item(mbc1_pkg::CMD_READ, 16'hFFFF, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_WRITE, 16'h8000, 17'h0, 8'h80);
        send_item(mbc1_pkg::CMD_READ, 16'h8000, 17'h0, 8'h00);
        send_item(mbc1_pkg::CMD_NOP, 16'hFFFF, 17'h1FFFF, 8'hFF);

        // Random phases over the register settings; a phase counts every item sent.
        for (int phase = 0; phase < 4; phase++)
        begin
            drain(DRAIN_WAIT);
            case (phase)
                0: set_config(1'b1, 1'b1);
                1: set_config(1'b0, 1'b0);
                2: set_config(1'b1, 1'b0);
                default: set_config(1'b0, 1'b1);
            endcase
            phase_end = sent_items + PHASE_ITEMS;
            half_done = 1'b0;
            while (sent_items < phase_end)
            begin
                if (!half_done && sent_items >= phase_end - PHASE_ITEMS / 2)
                begin
                    drain(0);
                    half_done = 1'b1;
                end
                random_item();
            end
        end

        drain(DRAIN_WAIT);
        if (error_count == 0)
            $display("PASS handheld_memory_map_mbc1");
        else
            $display("FAIL handheld_memory_map_mbc1");
        $finish;
    end

endmodule
